### rtl/kh64_pkg.sv
// Shared constants and types for the keyed 64-bit hash block.
`default_nettype none
package kh64_pkg;
	localparam logic [63:0] HK_S0 = 64'ha0761d6478bd642f;
	localparam logic [63:0] HK_S1 = 64'he7037ed1a0b428db;
	localparam logic [63:0] HK_S2 = 64'h8ebc6af09c88c6e3;
	localparam logic [63:0] HK_S3 = 64'h589965cc75374cc3;

	localparam int BUF_DEPTH = 8;
	localparam int BUF_AW    = 3;

	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} mul_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] result;
	} mul_rsp_t;
endpackage
`default_nettype wire

### rtl/keyed_hash64_stream.sv
// Keyed 64-bit streaming hash: word intake, lane rounds and final mix sequencer.
//
// Input stream s_*: one transfer per 64-bit key word, key_len on every word,
// s_tlast on the final word. Output stream m_*: one 64-bit hash per key.
// Configuration: cfg_wr_en/cfg_wr_data load the seed; write only while idle.
// One shared multiplier (four 32x32 partial products per mix) and an 8-entry
// word ring with a registered read port carry all the work. Per input
// transfer, a word that is only stored goes to the ring, a word that ends a
// 16-byte round adds one lane mix, a word that ends a 48-byte chunk adds
// three lane mixes, and the final word adds the finish (3 ring reads, 2 mixes).
// s_tready is high only while the sequencer waits for a word.
// The result sits in an output register; the next key streams in while it
// waits, and only a finished hash that finds the register full waits for
// m_tready. Reset clears the seed, lanes, byte count and output valid; the
// ring needs no clearing.
`default_nettype none
module keyed_hash64_stream (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [79:0] s_tdata,   // data_word[63:0], key_len[79:64]
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [63:0] m_tdata,   // hash_value[63:0]
	input  wire logic        cfg_wr_en,
	input  wire logic [63:0] cfg_wr_data
);
	import kh64_pkg::*;

	typedef enum logic [3:0] {
		IDLE, J_RD0, J_RD1, J_GO, J_WAIT,
		F_RD0, F_RD1, F_RD2, F_RD3, F_SEL, F_M1, F_W1, F_M2, F_W2, F_OUT
	} state_t;

	state_t state_q;

	logic [63:0] seed_q, lane_main_q, lane_second_q, lane_third_q;
	logic [15:0] bytes_seen_q;
	logic [2:0]  wmod6_q;
	logic [10:0] chunk_q;
	logic [15:0] len_q;
	logic        last_q, chunk_job_q, clast_q;
	logic [1:0]  lane_idx_q;
	logic [2:0]  jbase_q;
	logic [63:0] w0_q, w1_q, w2_q, a_q, b_q, t_q, res_q, m_tdata_q;
	logic        m_tvalid_q;

	mul_req_t mreq;
	mul_rsp_t mrsp;

	logic              ram_we;
	logic [BUF_AW-1:0] ram_waddr, ram_raddr;
	logic [63:0]       ram_rdata;

	// intake decode
	logic [15:0] len_in, pos;
	logic [16:0] len17, nb, b48, b48n;
	logic [12:0] w_in;
	logic        store, long_in, c_mix, c_last, r_mix;

	assign len_in = s_tdata[79:64];
	assign pos    = bytes_seen_q;
	assign w_in   = pos[15:3];
	assign len17  = {1'b0, len_in};
	assign store  = pos < len_in;
	assign nb     = {1'b0, w_in, 3'b000} + 17'd8;
	assign b48    = ({6'b0, chunk_q} << 5) + ({6'b0, chunk_q} << 4) + 17'd48;
	assign b48n   = b48 + 17'd48;
	assign long_in = len_in > 16'd16;
	assign c_mix  = store && long_in && (wmod6_q == 3'd5) && (b48 < len17);
	assign c_last = b48n >= len17;
	assign r_mix  = store && long_in && (b48 >= len17) && w_in[0] && (nb < len17);

	assign ram_we    = (state_q == IDLE) && s_tvalid && store;
	assign ram_waddr = w_in[2:0];

	// ring slots for lane rounds and the finish reads
	logic [2:0]  s0, s1, fa;
	logic [15:0] ldiff;
	logic        long_q;
	assign s0     = jbase_q + {lane_idx_q, 1'b0};
	assign s1     = s0 + 3'd1;
	assign long_q = len_q > 16'd16;
	assign ldiff  = len_q - 16'd16;
	assign fa     = long_q ? ldiff[5:3] : 3'd0;

	always_comb begin
		case (state_q)
			J_RD0:   ram_raddr = s0;
			J_RD1:   ram_raddr = s1;
			F_RD1:   ram_raddr = fa + 3'd1;
			F_RD2:   ram_raddr = fa + 3'd2;
			default: ram_raddr = fa;
		endcase
	end

	logic [63:0] kconst, lane_sel;
	always_comb begin
		case (lane_idx_q)
			2'd1: begin
				kconst   = HK_S2;
				lane_sel = lane_second_q;
			end
			2'd2: begin
				kconst   = HK_S3;
				lane_sel = lane_third_q;
			end
			default: begin
				kconst   = HK_S1;
				lane_sel = lane_main_q;
			end
		endcase
	end

	always_comb begin
		mreq.start = 1'b0;
		mreq.a     = w0_q ^ kconst;
		mreq.b     = ram_rdata ^ lane_sel;
		case (state_q)
			J_GO: mreq.start = 1'b1;
			F_M1: begin
				mreq.start = 1'b1;
				mreq.a     = a_q ^ HK_S1;
				mreq.b     = b_q ^ lane_main_q;
			end
			F_M2: begin
				mreq.start = 1'b1;
				mreq.a     = HK_S0 ^ {48'b0, len_q};
				mreq.b     = t_q;
			end
			default: mreq.start = 1'b0;
		endcase
	end

	// finish operand selection
	function automatic logic [31:0] rd4(input logic [127:0] v, input logic [3:0] p);
		logic [127:0] s;
		s = v >> {p, 3'b000};
		return s[31:0];
	endfunction

	function automatic logic [7:0] rd1(input logic [127:0] v, input logic [3:0] p);
		logic [127:0] s;
		s = v >> {p, 3'b000};
		return s[7:0];
	endfunction

	logic [127:0] v01, v12, lo_sh, hi_sh;
	logic [3:0]   q4, lm4, lmq;
	logic [4:0]   lm4_5;
	logic [63:0]  fin_a, fin_b;

	assign v01   = {w1_q, w0_q};
	assign v12   = {w2_q, w1_q};
	assign lo_sh = v01 >> {len_q[2:0], 3'b000};
	assign hi_sh = v12 >> {len_q[2:0], 3'b000};
	assign q4    = {len_q[4:3], 2'b00};
	assign lm4_5 = len_q[4:0] - 5'd4;
	assign lm4   = lm4_5[3:0];
	assign lmq   = lm4 - q4;

	always_comb begin
		if (long_q) begin
			fin_a = lo_sh[63:0];
			fin_b = hi_sh[63:0];
		end else if (len_q >= 16'd4) begin
			fin_a = {rd4(v01, 4'd0), rd4(v01, q4)};
			fin_b = {rd4(v01, lm4), rd4(v01, lmq)};
		end else if (len_q != 16'd0) begin
			fin_a = {40'b0, rd1(v01, 4'd0), rd1(v01, {1'b0, len_q[3:1]}),
				rd1(v01, len_q[3:0] - 4'd1)};
			fin_b = '0;
		end else begin
			fin_a = '0;
			fin_b = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= IDLE;
			seed_q        <= '0;
			lane_main_q   <= '0;
			lane_second_q <= '0;
			lane_third_q  <= '0;
			bytes_seen_q  <= '0;
			wmod6_q       <= '0;
			chunk_q       <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				seed_q <= cfg_wr_data;
			end
			if (m_tvalid_q && m_tready && state_q != F_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (s_tvalid) begin
						len_q       <= len_in;
						last_q      <= s_tlast;
						chunk_job_q <= c_mix;
						clast_q     <= c_last;
						lane_idx_q  <= '0;
						jbase_q     <= c_mix ? (w_in[2:0] - 3'd5) : (w_in[2:0] - 3'd1);
						if (pos == 16'd0) begin
							lane_main_q   <= seed_q ^ HK_S0;
							lane_second_q <= seed_q ^ HK_S0;
							lane_third_q  <= seed_q ^ HK_S0;
						end
						if (s_tlast) begin
							bytes_seen_q <= '0;
							wmod6_q      <= '0;
							chunk_q      <= '0;
						end else if (store) begin
							bytes_seen_q <= (nb > len17) ? len_in : nb[15:0];
							if (wmod6_q == 3'd5) begin
								wmod6_q <= '0;
								chunk_q <= chunk_q + 11'd1;
							end else begin
								wmod6_q <= wmod6_q + 3'd1;
							end
						end
						if (c_mix || r_mix) begin
							state_q <= J_RD0;
						end else if (s_tlast) begin
							state_q <= F_RD0;
						end
					end
				end
				J_RD0: state_q <= J_RD1;
				J_RD1: begin
					w0_q    <= ram_rdata;
					state_q <= J_GO;
				end
				J_GO: state_q <= J_WAIT;
				J_WAIT: begin
					if (mrsp.done) begin
						case (lane_idx_q)
							2'd1: lane_second_q <= mrsp.result;
							2'd2: begin
								lane_third_q <= mrsp.result;
								if (clast_q) begin
									lane_main_q <= lane_main_q ^ lane_second_q ^ mrsp.result;
								end
							end
							default: lane_main_q <= mrsp.result;
						endcase
						if (chunk_job_q && lane_idx_q != 2'd2) begin
							lane_idx_q <= lane_idx_q + 2'd1;
							state_q    <= J_RD0;
						end else if (last_q) begin
							state_q <= F_RD0;
						end else begin
							state_q <= IDLE;
						end
					end
				end
				F_RD0: state_q <= F_RD1;
				F_RD1: begin
					w0_q    <= ram_rdata;
					state_q <= F_RD2;
				end
				F_RD2: begin
					w1_q    <= ram_rdata;
					state_q <= F_RD3;
				end
				F_RD3: begin
					w2_q    <= ram_rdata;
					state_q <= F_SEL;
				end
				F_SEL: begin
					a_q     <= fin_a;
					b_q     <= fin_b;
					state_q <= F_M1;
				end
				F_M1: state_q <= F_W1;
				F_W1: begin
					if (mrsp.done) begin
						t_q     <= mrsp.result;
						state_q <= F_M2;
					end
				end
				F_M2: state_q <= F_W2;
				F_W2: begin
					if (mrsp.done) begin
						res_q   <= mrsp.result;
						state_q <= F_OUT;
					end
				end
				F_OUT: begin
					// output register free, or its transfer completes now
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= res_q;
						state_q    <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign s_tready = state_q == IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	kh64_ram #(
		.WIDTH(64),
		.DEPTH(BUF_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (s_tdata[63:0]),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	kh64_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);
endmodule
`default_nettype wire

### rtl/kh64_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module kh64_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### rtl/kh64_mul.sv
// Iterative 64x64 multiply-fold unit: lo64 ^ hi64 of the full product.
`default_nettype none
module kh64_mul (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire kh64_pkg::mul_req_t  req,
	output kh64_pkg::mul_rsp_t       rsp
);
	import kh64_pkg::*;

	logic [63:0]  a_q, b_q;
	logic [127:0] acc_q;
	logic [63:0]  pp_q;
	logic [1:0]   sh_q;
	logic [2:0]   cnt_q;
	logic         busy_q, done_q;
	logic [31:0]  pa, pb;

	// partial products in order a0b0, a0b1, a1b0, a1b1
	assign pa = cnt_q[1] ? a_q[63:32] : a_q[31:0];
	assign pb = cnt_q[0] ? b_q[63:32] : b_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			a_q    <= req.a;
			b_q    <= req.b;
			acc_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			if (cnt_q != 3'd4) begin
				pp_q <= pa * pb;
				sh_q <= {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
			end
			if (cnt_q != 3'd0) begin
				acc_q <= acc_q + ({64'b0, pp_q} << {sh_q, 5'b00000});
			end
			if (cnt_q == 3'd4) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
			cnt_q <= cnt_q + 3'd1;
		end else begin
			done_q <= 1'b0;
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = acc_q[63:0] ^ acc_q[127:64];
endmodule
`default_nettype wire

### tb/tb_top.sv
// Testbench for keyed_hash64_stream: directed table and random keys checked against a predictor.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import kh64_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic        cfg_wr_en = 1'b0;
	logic [63:0] cfg_wr_data = '0;

	keyed_hash64_stream dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	always #2 clk = ~clk;

	localparam int CYCLE_LIMIT = 3000000;

	// predictor state
	logic [63:0] p_seed, p_main, p_second, p_third;
	logic [63:0] p_ring [8];
	int unsigned p_seen;

	logic [63:0] hash_q [$];
	int   errors = 0;
	int   cycles = 0;
	bit   no_idle = 1'b0;
	int   words_sent = 0;
	int   stall_left = 0;

	function automatic logic [63:0] mix64(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[63:0] ^ p[127:64];
	endfunction

	function automatic logic [63:0] ring_byte(int unsigned pos);
		return (p_ring[(pos >> 3) & 7] >> ((pos & 7) * 8)) & 64'hff;
	endfunction

	function automatic logic [63:0] ring_read(int unsigned pos, int unsigned n);
		logic [63:0] v;
		v = '0;
		for (int k = 0; k < n; k++) v |= ring_byte(pos + k) << (8 * k);
		return v;
	endfunction

	task automatic lanes_absorb(int unsigned w, int unsigned len);
		int unsigned n48, n16, rem, cnt, b, d;
		n48 = 0; n16 = 0; cnt = w + 1;
		if (len <= 16) return;
		if (len > 48) n48 = (len - 1) / 48;
		rem = len - 48 * n48;
		if (rem > 16) n16 = (rem - 1) / 16;
		if (cnt % 6 == 0 && cnt / 6 <= n48) begin
			b = cnt - 6;
			p_main   = mix64(p_ring[b & 7] ^ HK_S1, p_ring[(b + 1) & 7] ^ p_main);
			p_second = mix64(p_ring[(b + 2) & 7] ^ HK_S2, p_ring[(b + 3) & 7] ^ p_second);
			p_third  = mix64(p_ring[(b + 4) & 7] ^ HK_S3, p_ring[(b + 5) & 7] ^ p_third);
			if (cnt / 6 == n48) p_main ^= p_second ^ p_third;
		end else if (cnt > 6 * n48) begin
			d = cnt - 6 * n48;
			if (d % 2 == 0 && d / 2 <= n16) begin
				b = cnt - 2;
				p_main = mix64(p_ring[b & 7] ^ HK_S1, p_ring[(b + 1) & 7] ^ p_main);
			end
		end
	endtask

	function automatic logic [63:0] finish_hash(int unsigned len);
		logic [63:0] a, b;
		int unsigned q;
		if (len <= 16) begin
			if (len >= 4) begin
				q = (len >> 3) << 2;
				a = (ring_read(0, 4) << 32) | ring_read(q, 4);
				b = (ring_read(len - 4, 4) << 32) | ring_read(len - 4 - q, 4);
			end else if (len > 0) begin
				a = (ring_byte(0) << 16) | (ring_byte(len >> 1) << 8) | ring_byte(len - 1);
				b = '0;
			end else begin
				a = '0; b = '0;
			end
		end else begin
			a = ring_read(len - 16, 8);
			b = ring_read(len - 8, 8);
		end
		return mix64(HK_S0 ^ 64'(len), mix64(a ^ HK_S1, b ^ p_main));
	endfunction

	// returns 1 and the hash when the word closes a key
	task automatic predict_word(logic [63:0] dw, logic [15:0] kl, logic lst,
			output bit has_out, output logic [63:0] h);
		int unsigned len, pos, w, nxt;
		len = kl; pos = p_seen; has_out = 0; h = '0;
		if (pos == 0) begin
			p_main = p_seed ^ HK_S0; p_second = p_main; p_third = p_main;
		end
		if (pos < len) begin
			w = pos >> 3;
			nxt = (w + 1) * 8;
			p_ring[w & 7] = dw;
			if (nxt > len) nxt = len;
			p_seen = nxt;
			lanes_absorb(w, len);
		end
		if (lst) begin
			h = finish_hash(len);
			p_seen = 0;
			has_out = 1;
		end
	endtask

	task automatic idle_gap();
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
	endtask

	// leaves s_tvalid high at the falling edge after the transfer
	task automatic send_word(logic [63:0] dw, logic [15:0] kl, logic lst);
		bit ho;
		logic [63:0] h;
		idle_gap();
		s_tvalid <= 1'b1;
		s_tdata  <= {kl, dw};
		s_tlast  <= lst;
		do @(posedge clk); while (!s_tready);
		predict_word(dw, kl, lst, ho, h);
		if (ho) hash_q.push_back(h);
		words_sent++;
		@(negedge clk);
	endtask

	// full key; an early last is avoided so no unwritten ring entry is read
	task automatic send_key(int unsigned len, bit pat);
		int unsigned nw;
		logic [63:0] dw;
		nw = (len == 0) ? 1 : (len + 7) / 8;
		for (int i = 0; i < nw; i++) begin
			dw = pat ? {8{8'(i * 8 + 1)}} : {$urandom, $urandom};
			send_word(dw, 16'(len), i == nw - 1);
		end
	endtask

	task automatic drain_then_config(logic [63:0] seed);
		s_tvalid <= 1'b0;
		while (hash_q.size() != 0) @(negedge clk);
		repeat (80) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= seed;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		p_seed = seed;
	endtask

	// sink with random stall bursts
	always @(negedge clk) begin
		if (no_idle) begin
			m_tready   <= 1'b1;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 7) == 0) begin
			m_tready   <= 1'b0;
			stall_left <= $urandom_range(0, 13);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		logic [63:0] exp_h;
		cycles <= cycles + 1;
		if (arst_n && m_tvalid && m_tready) begin
			if (hash_q.size() == 0) begin
				$error("unexpected hash transfer: hash_value actual %h", m_tdata);
				errors++;
			end else begin
				exp_h = hash_q.pop_front();
				if (m_tdata !== exp_h) begin
					$error("hash_value mismatch: expected %h actual %h", exp_h, m_tdata);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	typedef struct {
		logic [63:0] dw;
		logic [15:0] kl;
		logic        lst;
		bit          check_fixed;
		logic [63:0] fixed_hash;
	} row_t;

	row_t rows [$];

	initial begin
		logic [63:0] zero_hash;
		p_seed = '0; p_main = '0; p_second = '0; p_third = '0; p_seen = 0;
		foreach (p_ring[i]) p_ring[i] = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// zero-length key under seed 0: mix(S0, mix(S1, S0))
		zero_hash = mix64(HK_S0, mix64(HK_S1, HK_S0));
		rows.push_back('{64'hffff_ffff_ffff_ffff, 16'd0, 1'b1, 1, zero_hash});
		rows.push_back('{64'h0000_0000_0000_0000, 16'd0, 1'b1, 1, zero_hash});
		rows.push_back('{64'h0000_0000_0000_00ab, 16'd1, 1'b1, 0, '0});
		rows.push_back('{64'h0000_0000_00cc_bbaa, 16'd3, 1'b1, 0, '0});
		rows.push_back('{64'h0000_0000_ffff_ffff, 16'd4, 1'b1, 0, '0});
		rows.push_back('{64'hffff_ffff_ffff_ffff, 16'd8, 1'b1, 0, '0});
		rows.push_back('{64'h0123_4567_89ab_cdef, 16'd16, 1'b0, 0, '0});
		rows.push_back('{64'hfedc_ba98_7654_3210, 16'd16, 1'b1, 0, '0});
		// 17 bytes: one extra byte, bytes past the length set
		rows.push_back('{64'h1111_1111_1111_1111, 16'd17, 1'b0, 0, '0});
		rows.push_back('{64'h2222_2222_2222_2222, 16'd17, 1'b0, 0, '0});
		rows.push_back('{64'hffff_ffff_ffff_ff33, 16'd17, 1'b1, 0, '0});
		foreach (rows[i]) begin
			send_word(rows[i].dw, rows[i].kl, rows[i].lst);
			if (rows[i].check_fixed && hash_q[$] !== rows[i].fixed_hash) begin
				$error("hash_value table mismatch: expected %h actual %h",
					rows[i].fixed_hash, hash_q[$]);
				errors++;
			end
		end
		send_key(48, 1);
		send_key(49, 1);
		send_key(97, 0);
		send_key(200, 0);
		// one word of a short key, then a last word past the length
		send_word(64'h55, 16'd2, 1'b0);
		send_word(64'haa, 16'd2, 1'b1);

		drain_then_config(64'hffff_ffff_ffff_ffff);
		send_key(0, 0); send_key(15, 0); send_key(64, 0);
		for (int ph = 0; ph < 4; ph++) begin
			drain_then_config(ph == 3 ? 64'd0 : {$urandom, $urandom});
			if (ph == 3) no_idle = 1'b1;
			while (words_sent < 100 * (ph + 1) + 80) begin
				case ($urandom_range(0, 9))
					0, 1, 2: send_key($urandom_range(0, 16), 0);
					3, 4, 5: send_key($urandom_range(17, 64), 0);
					6, 7:    send_key($urandom_range(65, 200), 0);
					8:       send_key($urandom_range(201, 600), 0);
					default: begin
						// noise: one word of a short key, then a closing word that may lie past the length
						send_word({$urandom, $urandom}, 16'($urandom_range(1, 8)), 1'b0);
						send_word({$urandom, $urandom}, 16'($urandom_range(1, 8)), 1'b1);
					end
				endcase
			end
		end

		s_tvalid <= 1'b0;
		while (hash_q.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (errors == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end
endmodule
`default_nettype wire
